/* rtl/m3inv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_pkg
// Widths and transaction types of the 3x3 fixed-point matrix inverse core.
// ----------------------------------------------------------------------------
package m3inv_pkg;

	localparam int ELEMENT_WIDTH = 32;
	localparam int FRACTION_BITS = 16;

	localparam int EW   = ELEMENT_WIDTH;
	localparam int PW   = 2 * EW;            // element product
	localparam int CW   = PW + 1;            // cofactor
	localparam int HW   = CW - EW;           // cofactor upper part
	localparam int DW   = 3 * EW + 3;        // determinant
	localparam int NW   = CW + 2 * FRACTION_BITS;
	localparam int RW   = DW + EW;           // divider remainder
	localparam int QW   = EW + 1;            // quotient incl. overflow bit

	typedef logic signed [EW-1:0] elem_t;

	typedef struct packed {
		elem_t in_r0c0;
		elem_t in_r0c1;
		elem_t in_r0c2;
		elem_t in_r1c0;
		elem_t in_r1c1;
		elem_t in_r1c2;
		elem_t in_r2c0;
		elem_t in_r2c1;
		elem_t in_r2c2;
	} in_item_t;

	typedef struct packed {
		elem_t out_r0c0;
		elem_t out_r0c1;
		elem_t out_r0c2;
		elem_t out_r1c0;
		elem_t out_r1c1;
		elem_t out_r1c2;
		elem_t out_r2c0;
		elem_t out_r2c1;
		elem_t out_r2c2;
		logic  singular;
		logic  saturated;
	} out_item_t;

endpackage

/* rtl/m3inv_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_in_if
// Valid/ready channel carrying one input matrix per transaction.
// ----------------------------------------------------------------------------
interface m3inv_in_if import m3inv_pkg::*; ;
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/m3inv_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m3inv_out_if
// Valid/ready channel carrying one inverse matrix per transaction.
// ----------------------------------------------------------------------------
interface m3inv_out_if import m3inv_pkg::*; ;
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/matrix3x3_inverse_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// 3x3 signed Q16.16 matrix inverse by adjugate over determinant.
//
// Usage: one matrix per transaction on the matrix channel, one inverse per
// transaction on the inverse channel, in order. Elements are truncated toward
// zero and saturated; singular flags a zero determinant (all elements zero).
// Pipeline: 6 stages of products, cofactors and determinant, 33
// restoring-divider stages of one quotient bit each, one saturation stage.
// Throughput: one matrix per cycle while the output is not stalled; nine
// divider lanes run side by side, one per adjugate element.
// Stall: the whole pipeline holds while the output register is full and
// inverse.ready is low; matrix.ready is then low. Nothing is lost or repeated.
// Reset: arst_n clears all valid bits; the pipeline is empty afterwards and
// ready at once.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core import m3inv_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	m3inv_in_if.sink    matrix,
	m3inv_out_if.source inverse
);

	localparam int unsigned CA[9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int unsigned CB[9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int unsigned CC[9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int unsigned CD[9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [QW-1:0] quo;
		logic          qneg;
	} lane_t;

	typedef struct packed {
		lane_t [8:0]   lane;
		logic [DW-1:0] dmag;
		logic          zero;
	} dstep_t;

	logic pipe_en;
	elem_t m_in[9];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s8;
	logic [QW-1:0] v_s7;

	logic signed [PW-1:0]    pa_s1[9];
	logic signed [PW-1:0]    pb_s1[9];
	elem_t                   r0_s1[3];
	logic signed [CW-1:0]    cof_s2[9];
	elem_t                   r0_s2[3];
	logic signed [CW-1:0]    cof_s3[9];
	logic signed [2*EW:0]    lo_s3[3];
	logic signed [EW+HW-1:0] hi_s3[3];
	logic signed [CW-1:0]    cof_s4[9];
	logic signed [DW-1:0]    prod_s4[3];
	logic signed [CW-1:0]    cof_s5[9];
	logic signed [DW-1:0]    det_s5;
	logic [DW-1:0]           dmag_s6;
	logic                    dneg_s6;
	logic                    zero_s6;
	logic [CW-1:0]           nmag_s6[9];
	logic                    nneg_s6[9];
	dstep_t                  div_s7[QW];
	dstep_t                  div_in[QW];
	dstep_t                  div_out[QW];
	out_item_t               out_s8;
	elem_t                   res[9];
	logic [8:0]              sat_l;

	assign pipe_en      = !v_s8 || inverse.ready;
	assign matrix.ready = pipe_en;

	assign m_in[0] = matrix.data.in_r0c0;
	assign m_in[1] = matrix.data.in_r0c1;
	assign m_in[2] = matrix.data.in_r0c2;
	assign m_in[3] = matrix.data.in_r1c0;
	assign m_in[4] = matrix.data.in_r1c1;
	assign m_in[5] = matrix.data.in_r1c2;
	assign m_in[6] = matrix.data.in_r2c0;
	assign m_in[7] = matrix.data.in_r2c1;
	assign m_in[8] = matrix.data.in_r2c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= '0;
			v_s8 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= matrix.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= {v_s7[QW-2:0], v_s6};
			v_s8 <= v_s7[QW-1];
		end
	end

	// products, cofactors, determinant and their magnitudes and signs
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			for (int i = 0; i < 9; i++) begin
				pa_s1[i]  <= m_in[CA[i]] * m_in[CB[i]];
				pb_s1[i]  <= m_in[CC[i]] * m_in[CD[i]];
				cof_s2[i] <= CW'(pa_s1[i]) - CW'(pb_s1[i]);
				cof_s3[i] <= cof_s2[i];
				cof_s4[i] <= cof_s3[i];
				cof_s5[i] <= cof_s4[i];
			end
			for (int j = 0; j < 3; j++) begin
				r0_s1[j]   <= m_in[j];
				r0_s2[j]   <= r0_s1[j];
				lo_s3[j]   <= r0_s2[j] * $signed({1'b0, cof_s2[3*j][EW-1:0]});
				hi_s3[j]   <= r0_s2[j] * $signed(cof_s2[3*j][CW-1:EW]);
				prod_s4[j] <= (DW'(hi_s3[j]) <<< EW) + DW'(lo_s3[j]);
			end
			det_s5 <= prod_s4[0] + prod_s4[1] + prod_s4[2];
			dneg_s6 <= det_s5[DW-1];
			dmag_s6 <= det_s5[DW-1] ? $unsigned(-det_s5) : $unsigned(det_s5);
			zero_s6 <= (det_s5 == '0);
			for (int i = 0; i < 9; i++) begin
				nneg_s6[i] <= cof_s5[i][CW-1];
				nmag_s6[i] <= cof_s5[i][CW-1] ? $unsigned(-cof_s5[i]) : $unsigned(cof_s5[i]);
			end
		end
	end

	// restoring divider, one quotient bit per stage, MSB (overflow) first
	always_comb begin
		div_in[0].dmag = dmag_s6;
		div_in[0].zero = zero_s6;
		for (int i = 0; i < 9; i++) begin
			div_in[0].lane[i].rem  = RW'(nmag_s6[i]) << (2 * FRACTION_BITS);
			div_in[0].lane[i].quo  = '0;
			div_in[0].lane[i].qneg = nneg_s6[i] ^ dneg_s6;
		end
	end

	for (genvar s = 0; s < QW; s++) begin : g_div
		localparam int B = QW - 1 - s;
		logic [RW-1:0] dsh;

		if (s > 0) begin : g_link
			assign div_in[s] = div_s7[s-1];
		end

		assign dsh = RW'(div_in[s].dmag) << B;

		always_comb begin
			div_out[s] = div_in[s];
			for (int i = 0; i < 9; i++) begin
				if (div_in[s].lane[i].rem >= dsh) begin
					div_out[s].lane[i].rem = div_in[s].lane[i].rem - dsh;
					div_out[s].lane[i].quo = {div_in[s].lane[i].quo[QW-2:0], 1'b1};
				end else begin
					div_out[s].lane[i].quo = {div_in[s].lane[i].quo[QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				div_s7[s] <= div_out[s];
			end
		end
	end

	// saturation and sign
	always_comb begin
		logic [QW-1:0] lim;
		logic [QW-1:0] q;
		for (int i = 0; i < 9; i++) begin
			lim = QW'(1) << (EW - 1);
			if (!div_s7[QW-1].lane[i].qneg) begin
				lim = lim - QW'(1);
			end
			q = div_s7[QW-1].lane[i].quo;
			sat_l[i] = (q > lim);
			if (sat_l[i]) begin
				q = lim;
			end
			if (div_s7[QW-1].lane[i].qneg) begin
				q = -q;
			end
			res[i] = div_s7[QW-1].zero ? '0 : $signed(q[EW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			out_s8.out_r0c0  <= res[0];
			out_s8.out_r0c1  <= res[1];
			out_s8.out_r0c2  <= res[2];
			out_s8.out_r1c0  <= res[3];
			out_s8.out_r1c1  <= res[4];
			out_s8.out_r1c2  <= res[5];
			out_s8.out_r2c0  <= res[6];
			out_s8.out_r2c1  <= res[7];
			out_s8.out_r2c2  <= res[8];
			out_s8.singular  <= div_s7[QW-1].zero;
			out_s8.saturated <= !div_s7[QW-1].zero && (|sat_l);
		end
	end

	assign inverse.valid = v_s8;
	assign inverse.data  = out_s8;

	a_sing_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && out_s8.singular |-> !out_s8.saturated)
		else $error("singular result flagged saturated");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && out_s8.singular |-> out_s8.out_r0c0 == '0 && out_s8.out_r1c1 == '0
			&& out_s8.out_r2c2 == '0 && out_s8.out_r0c2 == '0)
		else $error("singular result has nonzero elements");

	a_div_advance: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_en && v_s7[0] |=> v_s7[1])
		else $error("divider stage lost a transaction");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(v_s7) && $stable(v_s6))
		else $error("pipeline moved during stall");

endmodule

/* tb/sv/matrix3x3_inverse_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core_tb
// Self-checking bench for the 3x3 fixed-point matrix inverse core.
// Matrices go in over the valid/ready channel and inverses come out the same
// way. Each accepted matrix is inverted by the bench's own exact-integer model
// and queued, and every inverse transaction is checked field by field. Random
// idle cycles on both channels cover stalls.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core_tb;
	import m3inv_pkg::*;

	typedef logic signed [255:0] big_t;

	class inverse_scoreboard;
		out_item_t pending[$];
		int        errors;

		function big_t adj_term(elem_t a, elem_t b, elem_t c, elem_t d);
			big_t p, q;
			p = big_t'(a) * big_t'(b);
			q = big_t'(c) * big_t'(d);
			return p - q;
		endfunction

		function void note_matrix(in_item_t m);
			elem_t     e[9];
			big_t      adj[9];
			big_t      det, num, quo, hi, lo;
			out_item_t r;
			elem_t     v[9];
			logic      clip;
			e = '{m.in_r0c0, m.in_r0c1, m.in_r0c2, m.in_r1c0, m.in_r1c1,
				m.in_r1c2, m.in_r2c0, m.in_r2c1, m.in_r2c2};
			adj[0] = adj_term(e[4], e[8], e[5], e[7]);
			adj[1] = adj_term(e[2], e[7], e[1], e[8]);
			adj[2] = adj_term(e[1], e[5], e[2], e[4]);
			adj[3] = adj_term(e[5], e[6], e[3], e[8]);
			adj[4] = adj_term(e[0], e[8], e[2], e[6]);
			adj[5] = adj_term(e[2], e[3], e[0], e[5]);
			adj[6] = adj_term(e[3], e[7], e[4], e[6]);
			adj[7] = adj_term(e[1], e[6], e[0], e[7]);
			adj[8] = adj_term(e[0], e[4], e[1], e[3]);
			det = big_t'(e[0]) * adj[0] + big_t'(e[1]) * adj[3] + big_t'(e[2]) * adj[6];
			hi = (big_t'(1) <<< (EW - 1)) - 1;
			lo = -(big_t'(1) <<< (EW - 1));
			clip = 1'b0;
			for (int i = 0; i < 9; i++) begin
				v[i] = '0;
				if (det != 0) begin
					num = adj[i] <<< (2 * FRACTION_BITS);
					quo = num / det;  // signed division truncates toward zero
					if (quo > hi) begin
						quo = hi;
						clip = 1'b1;
					end else if (quo < lo) begin
						quo = lo;
						clip = 1'b1;
					end
					v[i] = quo[EW-1:0];
				end
			end
			r.out_r0c0 = v[0]; r.out_r0c1 = v[1]; r.out_r0c2 = v[2];
			r.out_r1c0 = v[3]; r.out_r1c1 = v[4]; r.out_r1c2 = v[5];
			r.out_r2c0 = v[6]; r.out_r2c1 = v[7]; r.out_r2c2 = v[8];
			r.singular = (det == 0);
			r.saturated = clip;
			pending.push_back(r);
		endfunction

		function void check_inverse(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected inverse %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.out_r0c0 !== want.out_r0c0)
				$display("%0t: r0c0 exp %h got %h", $time, want.out_r0c0, got.out_r0c0);
			if (got.out_r0c1 !== want.out_r0c1)
				$display("%0t: r0c1 exp %h got %h", $time, want.out_r0c1, got.out_r0c1);
			if (got.out_r0c2 !== want.out_r0c2)
				$display("%0t: r0c2 exp %h got %h", $time, want.out_r0c2, got.out_r0c2);
			if (got.out_r1c0 !== want.out_r1c0)
				$display("%0t: r1c0 exp %h got %h", $time, want.out_r1c0, got.out_r1c0);
			if (got.out_r1c1 !== want.out_r1c1)
				$display("%0t: r1c1 exp %h got %h", $time, want.out_r1c1, got.out_r1c1);
			if (got.out_r1c2 !== want.out_r1c2)
				$display("%0t: r1c2 exp %h got %h", $time, want.out_r1c2, got.out_r1c2);
			if (got.out_r2c0 !== want.out_r2c0)
				$display("%0t: r2c0 exp %h got %h", $time, want.out_r2c0, got.out_r2c0);
			if (got.out_r2c1 !== want.out_r2c1)
				$display("%0t: r2c1 exp %h got %h", $time, want.out_r2c1, got.out_r2c1);
			if (got.out_r2c2 !== want.out_r2c2)
				$display("%0t: r2c2 exp %h got %h", $time, want.out_r2c2, got.out_r2c2);
			if (got.singular !== want.singular)
				$display("%0t: singular exp %b got %b", $time, want.singular, got.singular);
			if (got.saturated !== want.saturated)
				$display("%0t: saturated exp %b got %b", $time, want.saturated,
					got.saturated);
			if (got !== want)
				errors++;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   all_sent;

	m3inv_in_if  matrix_ch();
	m3inv_out_if inverse_ch();

	inverse_scoreboard sb;

	matrix3x3_inverse_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.matrix (matrix_ch.sink),
		.inverse(inverse_ch.source)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic elem_t rand_elem();
		case ($urandom_range(0, 7))
			0: return elem_t'($urandom);
			1: return elem_t'($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
			2: return elem_t'(0);
			3: return elem_t'(($urandom_range(0, 8) - 4) * 32'h0001_0000);
			4: return elem_t'($signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
			5: return elem_t'($signed($urandom_range(0, 255)) - 128);
			default: return elem_t'($signed($urandom_range(0, 32'h03ff_ffff)) -
				32'sh0200_0000);
		endcase
	endfunction

	function automatic in_item_t make_matrix(elem_t a0, elem_t a1, elem_t a2, elem_t b0,
		elem_t b1, elem_t b2, elem_t c0, elem_t c1, elem_t c2);
		in_item_t m;
		m.in_r0c0 = a0; m.in_r0c1 = a1; m.in_r0c2 = a2;
		m.in_r1c0 = b0; m.in_r1c1 = b1; m.in_r1c2 = b2;
		m.in_r2c0 = c0; m.in_r2c1 = c1; m.in_r2c2 = c2;
		return m;
	endfunction

	function automatic in_item_t random_matrix();
		in_item_t m;
		elem_t    k;
		m = make_matrix(rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
			rand_elem(), rand_elem(), rand_elem(), rand_elem());
		case ($urandom_range(0, 9))
			0: begin
				m.in_r1c0 = m.in_r0c0; m.in_r1c1 = m.in_r0c1; m.in_r1c2 = m.in_r0c2;
			end
			1: begin
				m.in_r0c2 = m.in_r0c0; m.in_r1c2 = m.in_r1c0; m.in_r2c2 = m.in_r2c0;
			end
			2: begin
				k = elem_t'($urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000);
				m = make_matrix(k, rand_elem() >>> 8, 0, 0, k, rand_elem() >>> 8, 0, 0, k);
			end
			default: ;
		endcase
		return m;
	endfunction

	// valid stays high between back-to-back transactions
	task automatic send_matrix(in_item_t m);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			matrix_ch.valid <= 1'b0;
			@(negedge clk);
		end
		matrix_ch.valid <= 1'b1;
		matrix_ch.data <= m;
		@(posedge clk);
		while (!matrix_ch.ready)
			@(posedge clk);
		sb.note_matrix(m);
		@(negedge clk);
	endtask

	always @(negedge clk)
		inverse_ch.ready <= arst_n && ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk)
		if (arst_n && inverse_ch.valid && inverse_ch.ready)
			sb.check_inverse(inverse_ch.data);

	initial begin
		in_item_t q;
		elem_t    one, mx, mn;
		sb = new();
		one = 32'h0001_0000;
		mx = 32'h7fff_ffff;
		mn = 32'h8000_0000;
		all_sent = 1'b0;
		send_idle_pct = 22;
		recv_idle_pct = 84;
		arst_n = 1'b0;
		matrix_ch.valid = 1'b0;
		matrix_ch.data = '0;
		inverse_ch.ready = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// identity, negated identity, zero, tiny, extremes, singular rows, scaled and permutation matrices
		send_matrix(make_matrix(one, 0, 0, 0, one, 0, 0, 0, one));
		send_matrix(make_matrix(-one, 0, 0, 0, -one, 0, 0, 0, -one));
		send_matrix('0);
		send_matrix(make_matrix(1, 0, 0, 0, 1, 0, 0, 0, 1));
		send_matrix(make_matrix(-1, 0, 0, 0, -1, 0, 0, 0, 1));
		send_matrix(make_matrix(mx, 0, 0, 0, mx, 0, 0, 0, mx));
		send_matrix(make_matrix(mn, 0, 0, 0, mn, 0, 0, 0, mn));
		send_matrix(make_matrix(mn, mx, mn, mx, mn, mx, mn, mx, mx));
		send_matrix(make_matrix(mx, mx, mx, mx, mx, mx, mx, mx, mx));
		send_matrix(make_matrix(mn, mn, mn, mn, mn, mn, mn, mn, mn));
		send_matrix(make_matrix(mn, 0, 0, 0, mx, 0, 0, 0, mn));
		send_matrix(make_matrix(one, 2 * one, 3 * one, 4 * one, 5 * one, 6 * one,
			7 * one, 8 * one, 9 * one));
		send_matrix(make_matrix(2 * one, one, 0, one, 2 * one, one, 0, one, 2 * one));
		send_matrix(make_matrix(3 * one, 0, 0, 0, 3 * one, 0, 0, 0, 3 * one));
		send_matrix(make_matrix(0, one, 0, 0, 0, one, one, 0, 0));
		send_matrix(make_matrix(0, -one, 0, one, 0, 0, 0, 0, -one));
		send_matrix(make_matrix(32'h0000_8000, 0, 0, 0, 32'hffff_8000, 0, 0, 0, 7));
		send_matrix(make_matrix(-1, -1, -1, -1, -1, -1, -1, -1, -1));

		for (int n = 0; n < 900; n++) begin
			if (n == 300) begin
				send_idle_pct = 84;
				recv_idle_pct = 22;
			end else if (n == 600) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			q = random_matrix();
			send_matrix(q);
		end
		matrix_ch.valid <= 1'b0;
		all_sent = 1'b1;
	end

	initial begin
		wait (all_sent);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("matrix3x3_inverse_core regression: pass");
		else
			$display("matrix3x3_inverse_core regression: fail");
		$finish;
	end

	initial begin
		#4000000;
		$display("matrix3x3_inverse_core regression: fail");
		$finish;
	end
endmodule

/* matrix3x3_inverse_core.f */
rtl/m3inv_pkg.sv
rtl/m3inv_in_if.sv
rtl/m3inv_out_if.sv
rtl/matrix3x3_inverse_core.sv
tb/sv/matrix3x3_inverse_core_tb.sv
